### sv/hsv_hsl_to_rgb_macros.svh
// ----------------------------------------------------------------------------
// hsv_hsl_to_rgb_macros.svh
// assertion macros shared by the color converter modules
// ----------------------------------------------------------------------------
`ifndef HSV_HSL_TO_RGB_MACROS_SVH
`define HSV_HSL_TO_RGB_MACROS_SVH

// condition must hold at every clock edge outside reset
`define HHR_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("hhr assertion failed");

// when pre holds, post must hold in the next cycle
`define HHR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hhr assertion failed");

`endif

### sv/hhr_pkg.sv
// ----------------------------------------------------------------------------
// hhr_pkg
// types and constants of the hsv/hsl to rgb color converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hhr_pkg;

   localparam int FRACTION_BITS = 12;

   // 1.0 in saturation / level units
   localparam logic [12:0] ONE_FRAC  = 13'd4096;
   localparam logic [12:0] HALF_FRAC = 13'd2048;

   // hue constants in 1/64 degree
   localparam logic signed [17:0] HUE_FULL_S  = 18'sd23040;
   localparam logic signed [17:0] HUE_TWICE_S = 18'sd46080;
   localparam logic [14:0]        HUE_SECTOR  = 15'd3840;

   // color space select
   localparam logic OP_HSV = 1'b0;
   localparam logic OP_HSL = 1'b1;

   typedef struct packed {
      logic               op;
      logic signed [15:0] hue;
      logic [12:0]        saturation;
      logic [12:0]        level;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // products and hue split after the front end
   typedef struct packed {
      logic        op;
      logic [2:0]  sector;
      logic [11:0] tfrac;
      logic [12:0] lvl;
      logic [24:0] p_sl;
      logic [23:0] p_smn;
   } prep_type;

   // channel terms scaled by the sector width
   typedef struct packed {
      logic [2:0]  sector;
      logic [36:0] x;
      logic [36:0] mz;
      logic [36:0] vf;
   } chroma_type;

endpackage

`default_nettype wire

### sv/hhr_prep.sv
// ----------------------------------------------------------------------------
// hhr_prep
// input clamp, hue wrap, sector split and first products (two stages)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_hsl_to_rgb_macros.svh"

module hhr_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  hhr_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output hhr_pkg::prep_type out_data
);

   logic              a_vld_ff, a_vld_in;
   logic              a_op_ff;
   logic [12:0]       a_sat_ff, a_sat_in;
   logic [12:0]       a_lvl_ff, a_lvl_in;
   logic [14:0]       a_hue_ff, a_hue_in;
   logic              b_vld_ff, b_vld_in;
   hhr_pkg::prep_type b_data_ff, b_data_in;
   logic              adv_a, adv_b;
   logic signed [17:0] hs, hwrap;
   logic [14:0]       base;
   logic [2:0]        sec;
   logic [14:0]       frac_w;
   logic [11:0]       frac;
   logic [11:0]       mn;
   logic [25:0]       p_sl_w;
   logic [24:0]       p_smn_w;

   // stage advance, a stage moves when empty or its successor moves
   assign adv_b    = !b_vld_ff || !out_stall;
   assign adv_a    = !a_vld_ff || adv_b;
   assign in_stall = !adv_a;

   // hue wrap into one turn and fraction clamp
   always_comb begin
      hs = {{2{in_data.hue[15]}}, in_data.hue};
      if (hs < -hhr_pkg::HUE_FULL_S) begin
         hwrap = hs + hhr_pkg::HUE_TWICE_S;
      end else if (hs < 18'sd0) begin
         hwrap = hs + hhr_pkg::HUE_FULL_S;
      end else if (hs >= hhr_pkg::HUE_FULL_S) begin
         hwrap = hs - hhr_pkg::HUE_FULL_S;
      end else begin
         hwrap = hs;
      end
      a_hue_in = hwrap[14:0];
      a_sat_in = (in_data.saturation > hhr_pkg::ONE_FRAC) ? hhr_pkg::ONE_FRAC
                                                         : in_data.saturation;
      a_lvl_in = (in_data.level > hhr_pkg::ONE_FRAC) ? hhr_pkg::ONE_FRAC
                                                    : in_data.level;
   end

   // sector, position in sector, min(l, 1-l) and products
   always_comb begin
      if (a_hue_ff >= 15'(5 * hhr_pkg::HUE_SECTOR)) begin
         sec = 3'd5;
      end else if (a_hue_ff >= 15'(4 * hhr_pkg::HUE_SECTOR)) begin
         sec = 3'd4;
      end else if (a_hue_ff >= 15'(3 * hhr_pkg::HUE_SECTOR)) begin
         sec = 3'd3;
      end else if (a_hue_ff >= 15'(2 * hhr_pkg::HUE_SECTOR)) begin
         sec = 3'd2;
      end else if (a_hue_ff >= hhr_pkg::HUE_SECTOR) begin
         sec = 3'd1;
      end else begin
         sec = 3'd0;
      end
      base   = 15'(sec * hhr_pkg::HUE_SECTOR);
      frac_w = a_hue_ff - base;
      frac   = frac_w[11:0];
      mn     = (a_lvl_ff < hhr_pkg::HALF_FRAC) ? a_lvl_ff[11:0]
                                               : 12'(hhr_pkg::ONE_FRAC - a_lvl_ff);
      p_sl_w  = {13'd0, a_sat_ff} * {13'd0, a_lvl_ff};
      p_smn_w = {12'd0, a_sat_ff} * {13'd0, mn};
      b_data_in.op     = a_op_ff;
      b_data_in.sector = sec;
      b_data_in.tfrac  = sec[0] ? 12'(hhr_pkg::HUE_SECTOR[11:0] - frac) : frac;
      b_data_in.lvl    = a_lvl_ff;
      b_data_in.p_sl   = p_sl_w[24:0];
      b_data_in.p_smn  = p_smn_w[23:0];
   end

   // valid bits
   assign a_vld_in = adv_a ? in_valid : a_vld_ff;
   assign b_vld_in = adv_b ? a_vld_ff : b_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv_a && in_valid) begin
         a_op_ff  <= in_data.op;
         a_sat_ff <= a_sat_in;
         a_lvl_ff <= a_lvl_in;
         a_hue_ff <= a_hue_in;
      end
      if (adv_b && a_vld_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_data  = b_data_ff;

   `HHR_ASSERT_ALWAYS(a_hue_wrapped, clock, reset,
      !a_vld_ff || (a_hue_ff < hhr_pkg::HUE_FULL_S[14:0]))
   `HHR_ASSERT_ALWAYS(b_sector_range, clock, reset,
      !b_vld_ff || (b_data_ff.sector <= 3'd5))

endmodule

`default_nettype wire

### sv/hhr_chroma.sv
// ----------------------------------------------------------------------------
// hhr_chroma
// value and chroma, then intermediate and offset terms (two stages)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_hsl_to_rgb_macros.svh"

module hhr_chroma (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  hhr_pkg::prep_type   in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output hhr_pkg::chroma_type out_data
);

   logic                c_vld_ff, c_vld_in;
   logic [2:0]          c_sector_ff;
   logic [11:0]         c_t_ff;
   logic [24:0]         c_v_ff, c_v_in;
   logic [24:0]         c_c_ff, c_c_in;
   logic                d_vld_ff, d_vld_in;
   hhr_pkg::chroma_type d_data_ff, d_data_in;
   logic                adv_c, adv_d;
   logic [24:0]         l12, c2, d;

   assign adv_d    = !d_vld_ff || !out_stall;
   assign adv_c    = !c_vld_ff || adv_d;
   assign in_stall = !adv_c;

   // hsv value and chroma in units of 2^-24
   always_comb begin
      l12 = {in_data.lvl, 12'd0};
      c2  = {in_data.p_smn, 1'b0};
      if (in_data.op == hhr_pkg::OP_HSV) begin
         c_v_in = l12;
         c_c_in = in_data.p_sl;
      end else begin
         c_v_in = l12 + {1'b0, in_data.p_smn};
         if (c_v_in == 25'd0) begin
            c_c_in = 25'd0;
         end else if (c2 > c_v_in) begin
            c_c_in = c_v_in;
         end else begin
            c_c_in = c2;
         end
      end
   end

   // intermediate term and offsets, all times the sector width
   always_comb begin
      d                = c_v_ff - c_c_ff;
      d_data_in.sector = c_sector_ff;
      d_data_in.x      = {12'd0, c_c_ff} * {25'd0, c_t_ff};
      d_data_in.mz     = {d, 12'd0} - {4'd0, d, 8'd0};
      d_data_in.vf     = {c_v_ff, 12'd0} - {4'd0, c_v_ff, 8'd0};
   end

   assign c_vld_in = adv_c ? in_valid : c_vld_ff;
   assign d_vld_in = adv_d ? c_vld_ff : d_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c && in_valid) begin
         c_sector_ff <= in_data.sector;
         c_t_ff      <= in_data.tfrac;
         c_v_ff      <= c_v_in;
         c_c_ff      <= c_c_in;
      end
      if (adv_d && c_vld_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_vld_ff;
   assign out_data  = d_data_ff;

   `HHR_ASSERT_ALWAYS(c_chroma_le_value, clock, reset, !c_vld_ff || (c_c_ff <= c_v_ff))

endmodule

`default_nettype wire

### sv/hhr_mix.sv
// ----------------------------------------------------------------------------
// hhr_mix
// channel placement by sector, then scale to 8 bits with rounding (two stages)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_hsl_to_rgb_macros.svh"

module hhr_mix (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  hhr_pkg::chroma_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output hhr_pkg::rsp_type    out_data
);

   logic             e_vld_ff, e_vld_in;
   logic [36:0]      e_r_ff, e_r_in;
   logic [36:0]      e_g_ff, e_g_in;
   logic [36:0]      e_b_ff, e_b_in;
   logic             f_vld_ff, f_vld_in;
   hhr_pkg::rsp_type f_data_ff, f_data_in;
   logic             adv_e, adv_f;
   logic [36:0]      val_c, val_x, val_z;

   assign adv_f    = !f_vld_ff || !out_stall;
   assign adv_e    = !e_vld_ff || adv_f;
   assign in_stall = !adv_e;

   // value * 255 / (2^24 * 3840) is value * 17 / 2^32; add half, then saturate
   function automatic logic [7:0] scale_chan(input logic [36:0] val);
      logic [41:0] w;
      w = {5'd0, val} + {1'b0, val, 4'd0} + {10'd1, 32'd0} - {10'd0, 32'h8000_0000};
      return (w[41:32] > 10'd255) ? 8'd255 : w[39:32];
   endfunction

   // place chroma, intermediate and zero terms, each plus the offset, by sector
   always_comb begin
      val_c = in_data.vf;
      val_x = in_data.x + in_data.mz;
      val_z = in_data.mz;
      case (in_data.sector)
         3'd0: begin
            e_r_in = val_c; e_g_in = val_x; e_b_in = val_z;
         end
         3'd1: begin
            e_r_in = val_x; e_g_in = val_c; e_b_in = val_z;
         end
         3'd2: begin
            e_r_in = val_z; e_g_in = val_c; e_b_in = val_x;
         end
         3'd3: begin
            e_r_in = val_z; e_g_in = val_x; e_b_in = val_c;
         end
         3'd4: begin
            e_r_in = val_x; e_g_in = val_z; e_b_in = val_c;
         end
         default: begin
            e_r_in = val_c; e_g_in = val_z; e_b_in = val_x;
         end
      endcase
   end

   always_comb begin
      f_data_in.red   = scale_chan(e_r_ff);
      f_data_in.green = scale_chan(e_g_ff);
      f_data_in.blue  = scale_chan(e_b_ff);
   end

   assign e_vld_in = adv_e ? in_valid : e_vld_ff;
   assign f_vld_in = adv_f ? e_vld_ff : f_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= e_vld_in;
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_e && in_valid) begin
         e_r_ff <= e_r_in;
         e_g_ff <= e_g_in;
         e_b_ff <= e_b_in;
      end
      if (adv_f && e_vld_ff) begin
         f_data_ff <= f_data_in;
      end
   end

   assign out_valid = f_vld_ff;
   assign out_data  = f_data_ff;

   `HHR_ASSERT_NEXT(e_held_on_stall, clock, reset, e_vld_ff && !adv_e, e_vld_ff)
   `HHR_ASSERT_NEXT(e_moves_to_f, clock, reset, e_vld_ff && adv_f, f_vld_ff)

endmodule

`default_nettype wire

### sv/hsv_hsl_to_rgb.sv
// six register stages with per-stage valid: a, b (prep), c, d (chroma), e, f (mix)
// throughput: one transaction per cycle while rsp_stall is low
// a stalled response holds only the stages that are full; bubbles close up
// reset clears the valid bits only; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
// hsv_hsl_to_rgb
// hsv / hsl color to 8-bit rgb converter, top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsv_hsl_to_rgb (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hhr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hhr_pkg::rsp_type rsp_data
);

   logic                prep_valid, prep_stall;
   hhr_pkg::prep_type   prep_data;
   logic                chroma_valid, chroma_stall;
   hhr_pkg::chroma_type chroma_data;

   // front end: clamp, wrap, products
   hhr_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_stall (prep_stall),
      .out_data  (prep_data)
   );

   // value, chroma and scaled terms
   hhr_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_stall  (prep_stall),
      .in_data   (prep_data),
      .out_valid (chroma_valid),
      .out_stall (chroma_stall),
      .out_data  (chroma_data)
   );

   // channel placement and 8-bit output
   hhr_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chroma_valid),
      .in_stall  (chroma_stall),
      .in_data   (chroma_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/hsv_hsl_to_rgb_test.sv
// ----------------------------------------------------------------------------
// hsv_hsl_to_rgb_test
// self-checking bench for the hsv / hsl to rgb converter: a queue-fed driver,
// a monitor and an exact integer predictor of each color transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_hsl_to_rgb_test;
   import hhr_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_colors[$];
   rsp_type expected_rgb[$];
   int      errors = 0;
   int      cycle_count = 0;
   bit      quiet_phase = 1'b0;
   bit      stim_done = 1'b0;
   int      req_gap = 0;
   int      rsp_hold = 0;

   hsv_hsl_to_rgb dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // round half up and clip one channel, num over the common denominator
   function automatic logic [7:0] round_channel(longint unsigned num);
      longint unsigned den;
      longint unsigned r;
      den = 64'd4096 * 64'd4096 * 64'd3840;
      r = (num * 2 + den) / (den * 2);
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   // exact conversion of one color to rgb
   function automatic rsp_type convert_color(req_type c);
      longint unsigned s, l, v, cr, mn, sector, frac, x, m, k;
      longint unsigned ch[3];
      int hw;
      rsp_type r;
      s = (c.saturation > 4096) ? 4096 : c.saturation;
      l = (c.level > 4096) ? 4096 : c.level;
      hw = int'(c.hue) % 23040;
      if (hw < 0) hw += 23040;
      if (c.op == OP_HSV) begin
         v = l * 4096;
         cr = s * l;
      end else begin
         mn = (l < 4096 - l) ? l : 4096 - l;
         v = l * 4096 + s * mn;
         cr = 2 * s * mn;
         if (v == 0) cr = 0;
         else if (cr > v) cr = v;
      end
      sector = hw / 3840;
      frac = hw % 3840;
      x = sector[0] ? cr * (3840 - frac) : cr * frac;
      m = (v - cr) * 3840;
      k = cr * 3840;
      case (sector)
         0: begin ch[0] = k; ch[1] = x; ch[2] = 0; end
         1: begin ch[0] = x; ch[1] = k; ch[2] = 0; end
         2: begin ch[0] = 0; ch[1] = k; ch[2] = x; end
         3: begin ch[0] = 0; ch[1] = x; ch[2] = k; end
         4: begin ch[0] = x; ch[1] = 0; ch[2] = k; end
         default: begin ch[0] = k; ch[1] = 0; ch[2] = x; end
      endcase
      r.red   = round_channel((ch[0] + m) * 255);
      r.green = round_channel((ch[1] + m) * 255);
      r.blue  = round_channel((ch[2] + m) * 255);
      return r;
   endfunction

   function automatic req_type make_color(logic op, int hue, int sat, int lvl);
      req_type c;
      c.op = op;
      c.hue = hue[15:0];
      c.saturation = sat[12:0];
      c.level = lvl[12:0];
      return c;
   endfunction

   // mostly in-range fractions, sometimes the whole 13-bit field
   function automatic int rand_fraction();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 8191);
         1: return 4096;
         2: return 0;
         3: return $urandom_range(2040, 2056);
         default: return $urandom_range(0, 4096);
      endcase
   endfunction

   // stimulus: directed corners, then random colors
   initial begin
      int hues[11];
      hues = '{0, 23040, -23040, 32767, -32768, 3840, 7680, 11520, 15360, 19200, -1};
      foreach (hues[i]) pending_colors.push_back(make_color(OP_HSV, hues[i], 4096, 4096));
      pending_colors.push_back(make_color(OP_HSV, 1000, 0, 4096));
      pending_colors.push_back(make_color(OP_HSV, 1000, 4096, 0));
      pending_colors.push_back(make_color(OP_HSV, 5000, 8191, 8191));
      pending_colors.push_back(make_color(OP_HSL, 2000, 4096, 0));
      pending_colors.push_back(make_color(OP_HSL, 2000, 4096, 2048));
      pending_colors.push_back(make_color(OP_HSL, 9000, 8191, 2048));
      pending_colors.push_back(make_color(OP_HSL, 9000, 4096, 4096));
      pending_colors.push_back(make_color(OP_HSL, 13000, 8191, 8191));
      pending_colors.push_back(make_color(OP_HSL, 17000, 0, 1234));
      pending_colors.push_back(make_color(OP_HSL, -5000, 3000, 3500));
      pending_colors.push_back(make_color(OP_HSL, 46080, 2048, 2048));
      repeat (1450)
         pending_colors.push_back(make_color($urandom_range(0, 1),
            $urandom_range(0, 65535), rand_fraction(), rand_fraction()));
   end

   // reset and run control
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_colors.size() < 150);
      quiet_phase = 1'b1;
      wait (pending_colors.size() == 0 && !req_valid);
      stim_done = 1'b1;
      wait (expected_rgb.size() == 0);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 200000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // driver: one transaction per accepted request, random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) expected_rgb.push_back(convert_color(req_data));
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
               req_gap <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_colors.size() > 0) begin
               req_data <= pending_colors.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted response and drive stall bursts
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb.size() == 0) begin
               $display("%0t unexpected response, actual %h", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_rgb.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t rgb mismatch, expected %h %h %h, actual %h %h %h", $time,
                     want.red, want.green, want.blue,
                     rsp_data.red, rsp_data.green, rsp_data.blue);
                  errors <= errors + 1;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_hold <= $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule
